// ----- rtl/core/hee_pkg.sv -----
// Package for the HTML entity escaper: character widths, entity kinds and
// the entity text tables used by the escaper pipeline.
// Depends on nothing.
`default_nettype none

package hee_pkg;

   localparam int CHAR_W = 16;
   localparam int IDX_W  = 3;

   localparam logic [CHAR_W-1:0] CH_QUOT = 16'h0022;
   localparam logic [CHAR_W-1:0] CH_AMP  = 16'h0026;
   localparam logic [CHAR_W-1:0] CH_LT   = 16'h003C;
   localparam logic [CHAR_W-1:0] CH_GT   = 16'h003E;
   localparam logic [CHAR_W-1:0] CH_NBSP = 16'h00A0;
   localparam logic [CHAR_W-1:0] CH_SEMI = 16'h003B;

   typedef enum logic [2:0] {
      ENT_NONE,
      ENT_QUOT,
      ENT_AMP,
      ENT_LT,
      ENT_GT,
      ENT_NBSP
   } entity_type;

   function automatic entity_type entity_of(input logic [CHAR_W-1:0] ch);
      entity_type kind;
      case (ch)
         CH_QUOT: kind = ENT_QUOT;
         CH_AMP:  kind = ENT_AMP;
         CH_LT:   kind = ENT_LT;
         CH_GT:   kind = ENT_GT;
         CH_NBSP: kind = ENT_NBSP;
         default: kind = ENT_NONE;
      endcase
      return kind;
   endfunction

   // Index of the final character of the run that a kind produces.
   function automatic logic [IDX_W-1:0] entity_last(input entity_type kind);
      logic [IDX_W-1:0] last;
      case (kind)
         ENT_QUOT: last = IDX_W'(5);
         ENT_AMP:  last = IDX_W'(4);
         ENT_LT:   last = IDX_W'(3);
         ENT_GT:   last = IDX_W'(3);
         ENT_NBSP: last = IDX_W'(5);
         default:  last = '0;
      endcase
      return last;
   endfunction

   function automatic logic [CHAR_W-1:0] entity_char(input entity_type kind,
                                                     input logic [IDX_W-1:0] idx);
      logic [7:0] c;
      c = ";";
      case (kind)
         ENT_QUOT: begin
            case (idx)
               3'd1:    c = "q";
               3'd2:    c = "u";
               3'd3:    c = "o";
               3'd4:    c = "t";
               default: c = ";";
            endcase
         end
         ENT_AMP: begin
            case (idx)
               3'd1:    c = "a";
               3'd2:    c = "m";
               3'd3:    c = "p";
               default: c = ";";
            endcase
         end
         ENT_LT: begin
            case (idx)
               3'd1:    c = "l";
               3'd2:    c = "t";
               default: c = ";";
            endcase
         end
         ENT_GT: begin
            case (idx)
               3'd1:    c = "g";
               3'd2:    c = "t";
               default: c = ";";
            endcase
         end
         ENT_NBSP: begin
            case (idx)
               3'd1:    c = "n";
               3'd2:    c = "b";
               3'd3:    c = "s";
               3'd4:    c = "p";
               default: c = ";";
            endcase
         end
         default: c = ";";
      endcase
      if (idx == '0) begin
         c = "&";
      end
      return {8'h00, c};
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/html_entity_escaper.sv -----
// HTML entity escaper: a four-stage pipeline that replaces five special
// characters with their entity text. Depends on hee_pkg.
//
// Each 16-bit character taken on the req_ channel produces one transfer on
// the rsp_ channel, or a run of four to six transfers for a double quote,
// ampersand, less-than, greater-than or non-breaking space (0xA0), which
// become &quot; &amp; &lt; &gt; and &nbsp;. Plain characters flow at one per
// cycle while rsp_tready is high and no entity is expanding, through s1, s2,
// the expansion stage and the output register. An entity stays in the expansion
// stage until its last character is sent, one character per cycle while
// rsp_tready is high, and holds back the input until then. rsp_tuser marks
// the last transfer of each run; rsp_tlast carries the input's req_tlast on
// that last transfer only. The block holds no state apart from the pipeline.
`default_nettype none

module html_entity_escaper (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   output logic                        req_tready,
   input  wire  [hee_pkg::CHAR_W-1:0]  req_tdata,   // [15:0] in_char
   input  wire                         req_tlast,   // in_string_end
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   output logic [hee_pkg::CHAR_W-1:0]  rsp_tdata,   // [15:0] out_char
   output logic                        rsp_tlast,   // out_string_end
   output logic                        rsp_tuser    // [0] out_run_last
);
   import hee_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   logic [CHAR_W-1:0] s1_char_ff, s1_char_in;
   logic              s1_end_ff, s1_end_in;
   logic              s1_ready;

   logic              s2_valid_ff, s2_valid_in;
   entity_type        s2_kind_ff, s2_kind_in;
   logic [IDX_W-1:0]  s2_last_ff, s2_last_in;
   logic [CHAR_W-1:0] s2_char_ff, s2_char_in;
   logic              s2_end_ff, s2_end_in;
   logic              s2_ready;

   logic              x_valid_ff, x_valid_in;
   entity_type        x_kind_ff, x_kind_in;
   logic [IDX_W-1:0]  x_last_ff, x_last_in;
   logic [IDX_W-1:0]  x_idx_ff, x_idx_in;
   logic [CHAR_W-1:0] x_char_ff, x_char_in;
   logic              x_end_ff, x_end_in;
   logic              x_ready, x_fire, x_done;
   logic [CHAR_W-1:0] x_char_out;

   logic              o_valid_ff, o_valid_in;
   logic [CHAR_W-1:0] o_char_ff, o_char_in;
   logic              o_run_last_ff, o_run_last_in;
   logic              o_end_ff, o_end_in;
   logic              o_ready;

   assign o_ready    = !o_valid_ff || rsp_tready;
   assign x_done     = (x_idx_ff == x_last_ff);
   assign x_fire     = x_valid_ff && o_ready;
   assign x_ready    = !x_valid_ff || (o_ready && x_done);
   assign s2_ready   = !s2_valid_ff || x_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;
   assign x_char_out = (x_kind_ff == ENT_NONE) ? x_char_ff
                                                : entity_char(x_kind_ff, x_idx_ff);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_char_in  = s1_char_ff;
      s1_end_in   = s1_end_ff;
      if (s1_ready) begin
         s1_valid_in = req_tvalid;
         s1_char_in  = req_tdata;
         s1_end_in   = req_tlast;
      end

      s2_valid_in = s2_valid_ff;
      s2_kind_in  = s2_kind_ff;
      s2_last_in  = s2_last_ff;
      s2_char_in  = s2_char_ff;
      s2_end_in   = s2_end_ff;
      if (s2_ready) begin
         s2_valid_in = s1_valid_ff;
         s2_kind_in  = entity_of(s1_char_ff);
         s2_last_in  = entity_last(entity_of(s1_char_ff));
         s2_char_in  = s1_char_ff;
         s2_end_in   = s1_end_ff;
      end

      x_valid_in = x_valid_ff;
      x_kind_in  = x_kind_ff;
      x_last_in  = x_last_ff;
      x_idx_in   = x_idx_ff;
      x_char_in  = x_char_ff;
      x_end_in   = x_end_ff;
      if (x_ready) begin
         x_valid_in = s2_valid_ff;
         x_kind_in  = s2_kind_ff;
         x_last_in  = s2_last_ff;
         x_idx_in   = '0;
         x_char_in  = s2_char_ff;
         x_end_in   = s2_end_ff;
      end else if (x_fire) begin
         x_idx_in = x_idx_ff + IDX_W'(1);
      end

      o_valid_in    = o_valid_ff;
      o_char_in     = o_char_ff;
      o_run_last_in = o_run_last_ff;
      o_end_in      = o_end_ff;
      if (o_ready) begin
         o_valid_in    = x_valid_ff;
         o_char_in     = x_char_out;
         o_run_last_in = x_done;
         o_end_in      = x_done && x_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         x_valid_ff  <= 1'b0;
         x_idx_ff    <= '0;
         o_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         x_valid_ff  <= x_valid_in;
         x_idx_ff    <= x_idx_in;
         o_valid_ff  <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_char_ff    <= s1_char_in;
      s1_end_ff     <= s1_end_in;
      s2_kind_ff    <= s2_kind_in;
      s2_last_ff    <= s2_last_in;
      s2_char_ff    <= s2_char_in;
      s2_end_ff     <= s2_end_in;
      x_kind_ff     <= x_kind_in;
      x_last_ff     <= x_last_in;
      x_char_ff     <= x_char_in;
      x_end_ff      <= x_end_in;
      o_char_ff     <= o_char_in;
      o_run_last_ff <= o_run_last_in;
      o_end_ff      <= o_end_in;
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = o_char_ff;
   assign rsp_tuser  = o_run_last_ff;
   assign rsp_tlast  = o_end_ff;

   a_end_only_on_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> !rsp_tlast)
      else $error("String end flagged before the last transfer of a run.");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      x_valid_ff |-> x_idx_ff <= x_last_ff)
      else $error("Expansion index ran past the end of the entity.");

   a_plain_single: assert property (@(posedge clock) disable iff (reset)
      x_valid_ff && x_kind_ff == ENT_NONE |-> x_last_ff == '0 && x_idx_ff == '0)
      else $error("Plain character expanded into more than one transfer.");

   a_entity_starts_amp: assert property (@(posedge clock) disable iff (reset)
      x_fire && x_kind_ff != ENT_NONE && x_idx_ff == '0 |=> rsp_tdata == CH_AMP)
      else $error("Entity run did not open with an ampersand.");

endmodule

`default_nettype wire
